// ----- rtl/core/tlr_pkg.sv -----
`default_nettype none

package tlr_pkg;

  // Line store geometry
  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

  // Telnet command bytes and options
  localparam logic [7:0] T_IAC    = 8'd255;
  localparam logic [7:0] T_DONT   = 8'd254;
  localparam logic [7:0] T_DO     = 8'd253;
  localparam logic [7:0] T_WONT   = 8'd252;
  localparam logic [7:0] T_WILL   = 8'd251;
  localparam logic [7:0] T_SB     = 8'd250;
  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;

  // Line control bytes
  localparam logic [7:0] C_CR    = 8'd13;
  localparam logic [7:0] C_LF    = 8'd10;
  localparam logic [7:0] C_EOT   = 8'd4;
  localparam logic [7:0] C_DEL   = 8'd127;
  localparam logic [7:0] C_SPACE = 8'd32;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_EOL   = 2'd2
  } kind_t;

  // Output source select
  typedef enum logic [1:0] {
    SEL_REPLY = 2'd0,
    SEL_LINE  = 2'd1,
    SEL_EXIT  = 2'd2,
    SEL_EOL   = 2'd3
  } sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic store_char;
    logic set_pending;
    logic set_swallow;
    logic clr_swallow;
    logic clr_line;
    logic clr_idx;
    logic inc_idx;
    logic out_load;
    sel_t out_sel;
  } tlr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_iac;
    logic is_sb;
    logic is_cmd;
    logic is_cr;
    logic is_lf;
    logic is_eot;
    logic is_drop;
    logic pend_reply;
    logic swallow;
    logic idx_at_len;
    logic idx_reply_end;
    logic idx_exit_end;
    logic out_free;
  } tlr_stat_t;

  // Characters of the "exit" line
  function automatic logic [7:0] exit_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h65;
      2'd1:    c = 8'h78;
      2'd2:    c = 8'h69;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tlr_ctrl.sv -----
`default_nettype none

module tlr_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_tvalid,
  output logic               s_tready,
  input  tlr_pkg::tlr_stat_t stat,
  output tlr_pkg::tlr_cmd_t  cmd
);
  import tlr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REPLY,
    ST_LINE_RD,
    ST_LINE,
    ST_EOL,
    ST_EXIT
  } state_t;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_IAC,
    MODE_CMD,
    MODE_SB
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;

  // Decode the held byte and sequence the result transactions
  always_comb begin
    cmd         = '0;
    cmd.out_sel = SEL_REPLY;
    state_next  = state;
    mode_next   = mode;
    case (state)
      ST_IDLE: begin
        cmd.accept = s_tvalid && s_tready;
        if (cmd.accept) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        case (mode)
          MODE_IAC: begin
            if (stat.is_iac) begin
              cmd.store_char = 1'b1;
              mode_next      = MODE_NORMAL;
            end else if (stat.is_sb) begin
              mode_next = MODE_SB;
            end else if (stat.is_cmd) begin
              cmd.set_pending = 1'b1;
              mode_next       = MODE_CMD;
            end else begin
              mode_next = MODE_NORMAL;
            end
          end
          MODE_CMD: begin
            mode_next = MODE_NORMAL;
            if (stat.pend_reply) begin
              cmd.clr_idx = 1'b1;
              state_next  = ST_REPLY;
            end
          end
          MODE_SB: begin
            if (stat.is_iac) begin
              mode_next = MODE_IAC;
            end
          end
          default: begin
            if (stat.is_iac) begin
              mode_next = MODE_IAC;
            end else if (stat.is_cr) begin
              cmd.set_swallow = 1'b1;
              cmd.clr_idx     = 1'b1;
              state_next      = ST_LINE_RD;
            end else if (stat.is_lf) begin
              if (stat.swallow) begin
                cmd.clr_swallow = 1'b1;
              end else begin
                cmd.clr_idx = 1'b1;
                state_next  = ST_LINE_RD;
              end
            end else if (stat.is_eot) begin
              cmd.clr_swallow = 1'b1;
              cmd.clr_line    = 1'b1;
              cmd.clr_idx     = 1'b1;
              state_next      = ST_EXIT;
            end else if (!stat.is_drop) begin
              cmd.store_char = 1'b1;
            end
          end
        endcase
      end
      ST_REPLY: begin
        cmd.out_sel = SEL_REPLY;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.inc_idx  = 1'b1;
          if (stat.idx_reply_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LINE_RD: begin
        state_next = stat.idx_at_len ? ST_EOL : ST_LINE;
      end
      ST_LINE: begin
        cmd.out_sel = SEL_LINE;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.inc_idx  = 1'b1;
          state_next   = ST_LINE_RD;
        end
      end
      ST_EXIT: begin
        cmd.out_sel = SEL_EXIT;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.inc_idx  = 1'b1;
          if (stat.idx_exit_end) begin
            state_next = ST_EOL;
          end
        end
      end
      ST_EOL: begin
        cmd.out_sel = SEL_EOL;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clr_line = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state, parse mode and the registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= MODE_NORMAL;
      s_tready <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      s_tready <= (state_next == ST_IDLE);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tlr_dpath.sv -----
`default_nettype none

module tlr_dpath (
  input  wire                clk,
  input  wire                rst,
  input  wire  [7:0]         s_tdata,
  input  tlr_pkg::tlr_cmd_t  cmd,
  output tlr_pkg::tlr_stat_t stat,
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [7:0]         m_tdata,
  output logic [2:0]         m_tuser,
  output logic               m_tlast
);
  import tlr_pkg::*;

  logic [7:0]       byte_q;
  logic [7:0]       pending;
  logic             swallow;
  logic [LEN_W-1:0] len;
  logic             ovf;
  logic [LEN_W-1:0] idx;
  logic [7:0]       line_mem [LINE_DEPTH];
  logic [7:0]       rd_data;
  logic             full;
  logic [7:0]       reply_cmd;
  logic [7:0]       out_data;
  kind_t            out_kind;
  logic             out_ovf;
  logic             out_last;

  assign full = (len == LEN_W'(LINE_DEPTH));

  // Classify the held byte
  always_comb begin
    stat.is_iac        = (byte_q == T_IAC);
    stat.is_sb         = (byte_q == T_SB);
    stat.is_cmd        = (byte_q >= T_WILL) && (byte_q <= T_DONT);
    stat.is_cr         = (byte_q == C_CR);
    stat.is_lf         = (byte_q == C_LF);
    stat.is_eot        = (byte_q == C_EOT);
    stat.is_drop       = (byte_q < C_SPACE) || (byte_q == C_DEL);
    stat.pend_reply    = (pending == T_DO) || (pending == T_WILL);
    stat.swallow       = swallow;
    stat.idx_at_len    = (idx == len);
    stat.idx_reply_end = (idx == LEN_W'(2));
    stat.idx_exit_end  = (idx == LEN_W'(3));
    stat.out_free      = !m_tvalid || m_tready;
  end

  // Pick the answer to a DO or WILL request
  always_comb begin
    if (pending == T_DO) begin
      reply_cmd = (byte_q == OPT_SGA) ? T_WILL : T_WONT;
    end else begin
      reply_cmd = ((byte_q == OPT_ECHO) || (byte_q == OPT_SGA)) ? T_DO : T_DONT;
    end
  end

  // Build the next result
  always_comb begin
    out_data = 8'd0;
    out_kind = KIND_REPLY;
    out_ovf  = 1'b0;
    out_last = 1'b0;
    case (cmd.out_sel)
      SEL_REPLY: begin
        case (idx[1:0])
          2'd0:    out_data = T_IAC;
          2'd1:    out_data = reply_cmd;
          default: out_data = byte_q;
        endcase
        out_last = (idx == LEN_W'(2));
      end
      SEL_LINE: begin
        out_kind = KIND_CHAR;
        out_data = rd_data;
      end
      SEL_EXIT: begin
        out_kind = KIND_CHAR;
        out_data = exit_char(idx[1:0]);
      end
      default: begin
        out_kind = KIND_EOL;
        out_ovf  = ovf;
        out_last = 1'b1;
      end
    endcase
  end

  // Capture the accepted byte
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= s_tdata;
    end
  end

  // Update parse registers, line bookkeeping and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 8'd0;
      swallow  <= 1'b0;
      len      <= '0;
      ovf      <= 1'b0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.set_pending) begin
        pending <= byte_q;
      end
      if (cmd.set_swallow) begin
        swallow <= 1'b1;
      end else if (cmd.clr_swallow) begin
        swallow <= 1'b0;
      end
      if (cmd.clr_line) begin
        len <= '0;
        ovf <= 1'b0;
      end else if (cmd.store_char) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          len <= len + LEN_W'(1);
        end
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + LEN_W'(1);
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Line store: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.store_char && !full) begin
      line_mem[len[ADDR_W-1:0]] <= byte_q;
    end
    rd_data <= line_mem[idx[ADDR_W-1:0]];
  end

  // Hold the result payload until taken
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= out_data;
      m_tuser <= {out_ovf, out_kind};
      m_tlast <= out_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/telnet_line_receiver_core.sv -----
// Channel  | Dir | Signals                           | Contents
// s_axis   | in  | s_tvalid s_tready s_tdata[7:0]    | received byte
// m_axis   | out | m_tvalid m_tready m_tdata[7:0]    | reply or line byte, zero on end of line
//          |     | m_tuser[2:0] m_tlast              | kind, overflow; last result of a byte
//
// A byte that produces no result occupies the block for capture and decode only.
// A negotiation reply then emits three results; each line character passes through a
// read state and an output state, as the line store's registered read feeds one output
// register. Ctrl-D then emits the four characters of "exit" and an end of line.
// Reset is synchronous; the line store contents are not cleared, only its length.
// A stalled m_tready holds the sequence in place; input is taken only when idle.
`default_nettype none

module telnet_line_receiver_core (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] data_byte
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [7:0] data
  output logic [2:0] m_tuser,   // [1:0] kind, [2] overflow
  output logic       m_tlast
);
  import tlr_pkg::*;

  tlr_cmd_t  cmd;
  tlr_stat_t stat;

  tlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlr_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/core/tlr_checker.sv -----
`default_nettype none

module tlr_checker (
  input wire       clk,
  input wire       rst,
  input wire       s_tvalid,
  input wire       s_tready,
  input wire [7:0] s_tdata,
  input wire       m_tvalid,
  input wire       m_tready,
  input wire [7:0] m_tdata,
  input wire [2:0] m_tuser,
  input wire       m_tlast
);
  import tlr_pkg::*;

  // Stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output payload changed under stall");

  // Only defined kinds appear
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[1:0] == KIND_REPLY) || (m_tuser[1:0] == KIND_CHAR)
      || (m_tuser[1:0] == KIND_EOL))
    else $error("undefined result kind");

  // Overflow marks only an end of line
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] != KIND_EOL) |-> !m_tuser[2])
    else $error("overflow on a non end-of-line result");

  // End of line is the last result and carries zero data
  a_eol: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == KIND_EOL) |-> m_tlast && (m_tdata == 8'd0))
    else $error("malformed end of line");

  // One byte at a time: ready drops after each input transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a byte is in decode");

endmodule

bind telnet_line_receiver_core tlr_checker u_tlr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
